### design/lzcc_pkg.sv
`timescale 1ns / 1ps

package lzcc_pkg;

  localparam int SampleWidth = 10;
  localparam int ThreshWidth = 4;
  localparam int CountWidth  = 4;
  localparam int ColorWidth  = 3;
  localparam int ZoneWidth   = 3;
  localparam int CfgIdxWidth = 2;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [ThreshWidth-1:0] thresh_t;
  typedef logic [CountWidth-1:0]  count_t;
  typedef logic [ColorWidth-1:0]  color_t;
  typedef logic [ZoneWidth-1:0]   zone_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_NEAR_THRESH = 2'd0;
  localparam cfg_idx_t REG_MID_THRESH  = 2'd1;
  localparam cfg_idx_t REG_FAR_THRESH  = 2'd2;

  localparam thresh_t NEAR_THRESH_RST = 4'd10;
  localparam thresh_t MID_THRESH_RST  = 4'd5;
  localparam thresh_t FAR_THRESH_RST  = 4'd2;

  // zone codes
  localparam zone_t ZONE_MIDDLE   = 3'd0;
  localparam zone_t ZONE_NEAR     = 3'd1;
  localparam zone_t ZONE_MID      = 3'd2;
  localparam zone_t ZONE_FAR      = 3'd3;
  localparam zone_t ZONE_FARTHEST = 3'd4;

  // zone boundaries, inclusive
  localparam sample_t MIDDLE_LO   = 10'h1FE;
  localparam sample_t MIDDLE_HI   = 10'h202;
  localparam sample_t NEAR_LO_LO  = 10'h181;
  localparam sample_t NEAR_LO_HI  = 10'h1FD;
  localparam sample_t NEAR_HI_LO  = 10'h203;
  localparam sample_t NEAR_HI_HI  = 10'h27F;
  localparam sample_t MID_LO_LO   = 10'h101;
  localparam sample_t MID_LO_HI   = 10'h180;
  localparam sample_t MID_HI_LO   = 10'h280;
  localparam sample_t MID_HI_HI   = 10'h2FF;
  localparam sample_t FAR_LO_LO   = 10'h081;
  localparam sample_t FAR_LO_HI   = 10'h100;
  localparam sample_t FAR_HI_LO   = 10'h300;
  localparam sample_t FAR_HI_HI   = 10'h37F;

  // led colors: bit0 red, bit1 green, bit2 blue
  localparam color_t COLOR_OFF    = 3'd0;
  localparam color_t COLOR_RED    = 3'd1;
  localparam color_t COLOR_GREEN  = 3'd2;
  localparam color_t COLOR_BLUE   = 3'd4;
  localparam color_t COLOR_PURPLE = 3'd5;
  localparam color_t COLOR_WHITE  = 3'd7;

  function automatic color_t next_color(input color_t c);
    color_t n;
    case (c)
      COLOR_RED:    n = COLOR_GREEN;
      COLOR_GREEN:  n = COLOR_BLUE;
      COLOR_BLUE:   n = COLOR_PURPLE;
      COLOR_PURPLE: n = COLOR_WHITE;
      default:      n = COLOR_RED;
    endcase
    return n;
  endfunction

endpackage

### design/lzcc_zone.sv
`timescale 1ns / 1ps

module lzcc_zone import lzcc_pkg::*; (
  input  sample_t sample,
  output zone_t   zone
);

  always_comb begin
    case (sample) inside
      [MIDDLE_LO:MIDDLE_HI]:                         zone = ZONE_MIDDLE;
      [NEAR_LO_LO:NEAR_LO_HI], [NEAR_HI_LO:NEAR_HI_HI]: zone = ZONE_NEAR;
      [MID_LO_LO:MID_LO_HI], [MID_HI_LO:MID_HI_HI]:     zone = ZONE_MID;
      [FAR_LO_LO:FAR_LO_HI], [FAR_HI_LO:FAR_HI_HI]:     zone = ZONE_FAR;
      default:                                       zone = ZONE_FARTHEST;
    endcase
  end

endmodule

### design/level_zone_color_cycler.sv
`timescale 1ns / 1ps

// level zone color cycler
// input channel: one 10-bit converter sample per word (in_valid / in_stall / sample),
//   one word per timer tick
// output channel: one result word per input word (out_valid / out_stall /
//   led_pattern, advanced, zone); led_pattern is the color after this tick
// config port: cfg_write with cfg_index 0 near, 1 mid, 2 far threshold, data in
//   cfg_data[3:0]; index 3 is ignored; write only while the block is idle
// path: a word passes through the input register, then the result register, where
//   out_valid rises; throughput one word per cycle while out_stall is low, set by the
//   combinational counter and color update between the two registers
// stall: a held result stays in the result register; one more word is taken into
//   the input register, after that in_stall follows out_stall
// reset: thresholds 10 / 5 / 2, tick counter 0, color all off, both stages empty
module level_zone_color_cycler import lzcc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  // input channel
  input  logic     in_valid,
  output logic     in_stall,
  input  sample_t  sample,
  // output channel
  output logic     out_valid,
  input  logic     out_stall,
  output color_t   led_pattern,
  output logic     advanced,
  output zone_t    zone,
  // config port
  input  logic     cfg_write,
  input  cfg_idx_t cfg_index,
  input  thresh_t  cfg_data
);

  // configuration registers
  thresh_t near_thresh;
  thresh_t mid_thresh;
  thresh_t far_thresh;

  // block state
  count_t tick_count;
  count_t tick_count_next;
  color_t color;
  color_t color_next;
  logic   adv_next;

  // input stage
  logic    s1_valid;
  sample_t s1_sample;
  zone_t   s1_zone;

  // stage handshake
  logic out_load;
  logic in_take;

  // counter work
  thresh_t                th;
  logic [CountWidth:0]    count_inc;
  logic                   over;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_thresh <= NEAR_THRESH_RST;
      mid_thresh  <= MID_THRESH_RST;
      far_thresh  <= FAR_THRESH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NEAR_THRESH: near_thresh <= cfg_data;
        REG_MID_THRESH:  mid_thresh  <= cfg_data;
        REG_FAR_THRESH:  far_thresh  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample <= sample;
    end
  end

  lzcc_zone u_zone (
    .sample (s1_sample),
    .zone   (s1_zone)
  );

  // threshold for the current zone
  always_comb begin
    case (s1_zone)
      ZONE_NEAR: th = near_thresh;
      ZONE_MID:  th = mid_thresh;
      default:   th = far_thresh;
    endcase
  end

  // 5-bit increment so 16 always exceeds any threshold
  assign count_inc = {1'b0, tick_count} + {{CountWidth{1'b0}}, 1'b1};
  assign over      = count_inc > {1'b0, th};

  always_comb begin
    tick_count_next = tick_count;
    color_next      = color;
    adv_next        = 1'b0;
    case (s1_zone)
      ZONE_MIDDLE: begin
        tick_count_next = '0;
      end
      ZONE_FARTHEST: begin
        color_next = next_color(color);
        adv_next   = 1'b1;
      end
      default: begin
        if (over) begin
          color_next      = next_color(color);
          adv_next        = 1'b1;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc[CountWidth-1:0];
        end
      end
    endcase
  end

  // state advances as the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      color      <= COLOR_OFF;
    end else if (out_load) begin
      tick_count <= tick_count_next;
      color      <= color_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      led_pattern <= color_next;
      advanced    <= adv_next;
      zone        <= s1_zone;
    end
  end

  // farthest zone always advances, the middle never does
  assert property (@(posedge clk) disable iff (rst)
    out_valid && zone == ZONE_FARTHEST |-> advanced)
    else $error("farthest zone word without advance");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && zone == ZONE_MIDDLE |-> !advanced)
    else $error("middle zone word advanced");

  // an advance always lands on a defined color
  assert property (@(posedge clk) disable iff (rst)
    out_valid && advanced |-> (led_pattern == COLOR_RED || led_pattern == COLOR_GREEN ||
      led_pattern == COLOR_BLUE || led_pattern == COLOR_PURPLE ||
      led_pattern == COLOR_WHITE))
    else $error("advance to undefined color");

  // input only waits behind a full input stage that cannot drain
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

endmodule
